// ===== rtl/core/mhpq_pkg.sv =====
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int KEY_W     = 32;
    localparam int COUNT_W   = 7;
    localparam int CAPACITY  = 127;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = CNT_W;
    localparam int CHILD_W   = ADDR_W + 1;
    localparam int DEPTH     = 1 << ADDR_W;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_INS_SETUP,
        A_RD_PARENT,
        A_UP_MOVE,
        A_RD_TOP,
        A_RD_LAST,
        A_REM_SETUP,
        A_RD_LEFT,
        A_RD_RIGHT,
        A_PICK_RIGHT,
        A_DN_MOVE,
        A_WR_KEY,
        A_SET_FULL,
        A_SET_EMPTY,
        A_FINISH
    } act_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_FUNC,
        C_FULL,
        C_EMPTY,
        C_ROOT,
        C_UP_LESS,
        C_NO_LEFT,
        C_HAS_RIGHT,
        C_RIGHT_BIG,
        C_CHILD_BIG,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_CHK_FULL,
        S_INS_SETUP,
        S_UP_TEST,
        S_UP_MOVE,
        S_CHK_EMPTY,
        S_RD_TOP,
        S_RD_LAST,
        S_REM_SETUP,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_PICK_RIGHT,
        S_DN_MOVE,
        S_WR_KEY,
        S_TOP_RD,
        S_FINISH,
        S_REF_FULL,
        S_REF_EMPTY
    } step_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jt;
        step_t jf;
    } ucode_t;

    typedef struct packed {
        act_t act;
        logic go;
    } ctrl_t;

    typedef struct packed {
        logic func;
        logic full;
        logic empty;
        logic root;
        logic up_less;
        logic no_left;
        logic has_right;
        logic right_big;
        logic child_big;
        logic out_free;
    } flags_t;

    function automatic ucode_t mk(input act_t a, input cond_t c, input step_t t, input step_t f);
        ucode_t w;
        w.act  = a;
        w.cond = c;
        w.jt   = t;
        w.jf   = f;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        case (s)
            S_IDLE:       w = mk(A_ACCEPT,     C_IN_VALID,  S_DISP,       S_IDLE);
            S_DISP:       w = mk(A_NONE,       C_FUNC,      S_CHK_EMPTY,  S_CHK_FULL);
            S_CHK_FULL:   w = mk(A_NONE,       C_FULL,      S_REF_FULL,   S_INS_SETUP);
            S_INS_SETUP:  w = mk(A_INS_SETUP,  C_ALWAYS,    S_UP_TEST,    S_UP_TEST);
            S_UP_TEST:    w = mk(A_RD_PARENT,  C_ROOT,      S_WR_KEY,     S_UP_MOVE);
            S_UP_MOVE:    w = mk(A_UP_MOVE,    C_UP_LESS,   S_UP_TEST,    S_WR_KEY);
            S_CHK_EMPTY:  w = mk(A_NONE,       C_EMPTY,     S_REF_EMPTY,  S_RD_TOP);
            S_RD_TOP:     w = mk(A_RD_TOP,     C_ALWAYS,    S_RD_LAST,    S_RD_LAST);
            S_RD_LAST:    w = mk(A_RD_LAST,    C_ALWAYS,    S_REM_SETUP,  S_REM_SETUP);
            S_REM_SETUP:  w = mk(A_REM_SETUP,  C_ALWAYS,    S_DN_LEFT,    S_DN_LEFT);
            S_DN_LEFT:    w = mk(A_RD_LEFT,    C_NO_LEFT,   S_WR_KEY,     S_DN_RIGHT);
            S_DN_RIGHT:   w = mk(A_RD_RIGHT,   C_HAS_RIGHT, S_PICK_RIGHT, S_DN_MOVE);
            S_PICK_RIGHT: w = mk(A_PICK_RIGHT, C_RIGHT_BIG, S_DN_MOVE,    S_DN_MOVE);
            S_DN_MOVE:    w = mk(A_DN_MOVE,    C_CHILD_BIG, S_DN_LEFT,    S_WR_KEY);
            S_WR_KEY:     w = mk(A_WR_KEY,     C_ALWAYS,    S_TOP_RD,     S_TOP_RD);
            S_TOP_RD:     w = mk(A_RD_TOP,     C_ALWAYS,    S_FINISH,     S_FINISH);
            S_FINISH:     w = mk(A_FINISH,     C_OUT_FREE,  S_IDLE,       S_FINISH);
            S_REF_FULL:   w = mk(A_SET_FULL,   C_ALWAYS,    S_TOP_RD,     S_TOP_RD);
            S_REF_EMPTY:  w = mk(A_SET_EMPTY,  C_ALWAYS,    S_TOP_RD,     S_TOP_RD);
            default:      w = mk(A_NONE,       C_ALWAYS,    S_IDLE,       S_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/max_heap_priority_queue.sv =====
// Insert climbs the new key toward the root while its parent is smaller; remove moves
// the last key to the root and sinks it while a child is bigger, taking the larger child.
// A full 127-entry heap has 7 levels. A held result stalls the next transaction.
// One transaction at a time on a single-port heap memory. Reset clears count and
// output valid, not memory.
`timescale 1ns / 1ps

module max_heap_priority_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic signed [31:0] key_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] removed_key,
    output logic signed [31:0] top_key,
    output logic [6:0]         entry_count,
    output logic [1:0]         status
);
    import mhpq_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    mhpq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .flags    (flags),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    mhpq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .func        (func),
        .key_in      (key_in),
        .out_ready   (out_ready),
        .flags       (flags),
        .out_valid   (out_valid),
        .removed_key (removed_key),
        .top_key     (top_key),
        .entry_count (entry_count),
        .status      (status)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= COUNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (entry_count == COUNT_W'(CAPACITY)))
        else $error("full refusal with heap not full");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |->
            (entry_count == '0 && top_key == '0 && removed_key == '0))
        else $error("empty refusal with nonzero result");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && entry_count == '0) |-> (top_key == '0))
        else $error("empty heap shows a top key");

endmodule

// ===== rtl/core/mhpq_seq.sv =====
`timescale 1ns / 1ps

module mhpq_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  mhpq_pkg::flags_t flags,
    output mhpq_pkg::ctrl_t ctrl,
    output logic            in_ready
);
    import mhpq_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.cond)
            C_ALWAYS:    go = 1'b1;
            C_IN_VALID:  go = in_valid;
            C_FUNC:      go = flags.func;
            C_FULL:      go = flags.full;
            C_EMPTY:     go = flags.empty;
            C_ROOT:      go = flags.root;
            C_UP_LESS:   go = flags.up_less;
            C_NO_LEFT:   go = flags.no_left;
            C_HAS_RIGHT: go = flags.has_right;
            C_RIGHT_BIG: go = flags.right_big;
            C_CHILD_BIG: go = flags.child_big;
            C_OUT_FREE:  go = flags.out_free;
            default:     go = 1'b0;
        endcase
        step_next = go ? word.jt : word.jf;
        ctrl.act  = word.act;
        ctrl.go   = go;
    end

    assign in_ready = (step_reg == S_IDLE);

endmodule

// ===== rtl/core/mhpq_datapath.sv =====
`timescale 1ns / 1ps

module mhpq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mhpq_pkg::ctrl_t               ctrl,
    input  logic                          func,
    input  logic signed [mhpq_pkg::KEY_W-1:0] key_in,
    input  logic                          out_ready,
    output mhpq_pkg::flags_t              flags,
    output logic                          out_valid,
    output logic signed [mhpq_pkg::KEY_W-1:0] removed_key,
    output logic signed [mhpq_pkg::KEY_W-1:0] top_key,
    output logic [mhpq_pkg::COUNT_W-1:0]  entry_count,
    output logic [1:0]                    status
);
    import mhpq_pkg::*;

    logic [KEY_W-1:0]   mem [0:DEPTH-1];
    logic [KEY_W-1:0]   mem_q;
    logic [ADDR_W-1:0]  mem_addr;
    logic [KEY_W-1:0]   mem_wdata;
    logic               mem_we;
    logic               mem_re;

    logic               func_reg,       func_next;
    logic [KEY_W-1:0]   key_reg,        key_next;
    logic [CNT_W-1:0]   cnt_reg,        cnt_next;
    logic [ADDR_W-1:0]  pos_reg,        pos_next;
    logic [KEY_W-1:0]   best_reg,       best_next;
    logic [ADDR_W-1:0]  best_pos_reg,   best_pos_next;
    logic [KEY_W-1:0]   removed_reg,    removed_next;
    status_t            status_reg,     status_next;
    logic               out_valid_reg,  out_valid_next;
    logic [KEY_W-1:0]   out_removed_reg, out_removed_next;
    logic [KEY_W-1:0]   out_top_reg,    out_top_next;
    logic [CNT_W-1:0]   out_cnt_reg,    out_cnt_next;
    status_t            out_status_reg, out_status_next;

    logic [CHILD_W-1:0] left_pos;
    logic [CHILD_W-1:0] right_pos;
    logic [CHILD_W-1:0] cnt_ext;

    assign left_pos  = {pos_reg, 1'b0};
    assign right_pos = {pos_reg, 1'b1};
    assign cnt_ext   = {1'b0, cnt_reg};

    always_comb
    begin
        flags.func      = func_reg;
        flags.full      = (cnt_reg == CNT_W'(CAPACITY));
        flags.empty     = (cnt_reg == '0);
        flags.root      = (pos_reg == ADDR_W'(1));
        flags.up_less   = ($signed(mem_q) < $signed(key_reg));
        flags.no_left   = (left_pos > cnt_ext);
        flags.has_right = (right_pos <= cnt_ext);
        flags.right_big = ($signed(mem_q) > $signed(best_reg));
        flags.child_big = ($signed(best_reg) > $signed(key_reg));
        flags.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        mem_addr  = pos_reg;
        mem_wdata = key_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        case (ctrl.act)
            A_RD_PARENT:
            begin
                mem_addr = pos_reg >> 1;
                mem_re   = 1'b1;
            end
            A_UP_MOVE:
            begin
                mem_wdata = mem_q;
                mem_we    = ctrl.go;
            end
            A_RD_TOP:
            begin
                mem_addr = ADDR_W'(1);
                mem_re   = 1'b1;
            end
            A_RD_LAST:
            begin
                mem_addr = cnt_reg;
                mem_re   = 1'b1;
            end
            A_RD_LEFT:
            begin
                mem_addr = left_pos[ADDR_W-1:0];
                mem_re   = 1'b1;
            end
            A_RD_RIGHT:
            begin
                mem_addr = right_pos[ADDR_W-1:0];
                mem_re   = 1'b1;
            end
            A_DN_MOVE:
            begin
                mem_wdata = best_reg;
                mem_we    = ctrl.go;
            end
            A_WR_KEY:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_addr];
        end
    end

    always_comb
    begin
        func_next        = func_reg;
        key_next         = key_reg;
        cnt_next         = cnt_reg;
        pos_next         = pos_reg;
        best_next        = best_reg;
        best_pos_next    = best_pos_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        out_removed_next = out_removed_reg;
        out_top_next     = out_top_reg;
        out_cnt_next     = out_cnt_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        case (ctrl.act)
            A_ACCEPT:
            begin
                if (ctrl.go)
                begin
                    func_next    = func;
                    key_next     = key_in;
                    removed_next = '0;
                    status_next  = ST_OK;
                end
            end
            A_INS_SETUP:
            begin
                cnt_next = cnt_reg + 1'b1;
                pos_next = cnt_reg + 1'b1;
            end
            A_UP_MOVE:
            begin
                if (ctrl.go)
                begin
                    pos_next = pos_reg >> 1;
                end
            end
            A_RD_LAST:
            begin
                removed_next = mem_q;
            end
            A_REM_SETUP:
            begin
                key_next = mem_q;
                cnt_next = cnt_reg - 1'b1;
                pos_next = ADDR_W'(1);
            end
            A_RD_RIGHT:
            begin
                best_next     = mem_q;
                best_pos_next = left_pos[ADDR_W-1:0];
            end
            A_PICK_RIGHT:
            begin
                if (ctrl.go)
                begin
                    best_next     = mem_q;
                    best_pos_next = right_pos[ADDR_W-1:0];
                end
            end
            A_DN_MOVE:
            begin
                if (ctrl.go)
                begin
                    pos_next = best_pos_reg;
                end
            end
            A_SET_FULL:
            begin
                status_next = ST_FULL;
            end
            A_SET_EMPTY:
            begin
                status_next = ST_EMPTY;
            end
            A_FINISH:
            begin
                if (ctrl.go)
                begin
                    out_removed_next = removed_reg;
                    out_top_next     = (cnt_reg != '0) ? mem_q : '0;
                    out_cnt_next     = cnt_reg;
                    out_status_next  = status_reg;
                    out_valid_next   = 1'b1;
                end
            end
            default:
            begin
                func_next = func_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        key_reg         <= key_next;
        pos_reg         <= pos_next;
        best_reg        <= best_next;
        best_pos_reg    <= best_pos_next;
        removed_reg     <= removed_next;
        status_reg      <= status_next;
        out_removed_reg <= out_removed_next;
        out_top_reg     <= out_top_next;
        out_cnt_reg     <= out_cnt_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign removed_key = $signed(out_removed_reg);
    assign top_key     = $signed(out_top_reg);
    assign entry_count = COUNT_W'(out_cnt_reg);
    assign status      = out_status_reg;

endmodule

// ===== tb/sv/tb_max_heap_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

    import mhpq_pkg::status_t;
    import mhpq_pkg::ST_OK;
    import mhpq_pkg::ST_FULL;
    import mhpq_pkg::ST_EMPTY;
    import mhpq_pkg::CAPACITY;

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_REMOVE   = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   REPORT_MAX  = 10;

    typedef struct {
        logic signed [31:0] removed;
        logic signed [31:0] top;
        logic [6:0]         count;
        status_t            st;
    } heap_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = OP_INSERT;
    logic signed [31:0] key_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] removed_key;
    logic signed [31:0] top_key;
    logic [6:0]         entry_count;
    logic [1:0]         status;

    logic signed [31:0] model_heap [1:CAPACITY];
    int unsigned        model_count = 0;
    heap_result_t       pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int checked_count = 0;
    int insert_count = 0;
    int remove_count = 0;
    int full_refusals = 0;
    int empty_refusals = 0;
    int quiet_cycles = 0;

    max_heap_priority_queue DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .key_in      (key_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .removed_key (removed_key),
        .top_key     (top_key),
        .entry_count (entry_count),
        .status      (status)
    );

    always #5 clk = ~clk;

    function automatic heap_result_t apply_heap_op(input logic op, input logic signed [31:0] k);
        heap_result_t       r;
        int unsigned        pos;
        int unsigned        lc;
        int unsigned        rc;
        int unsigned        big;
        logic signed [31:0] t;
        logic               settled;
        r.removed = '0;
        r.st = ST_OK;
        if (op == OP_INSERT)
        begin
            if (model_count >= CAPACITY)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                model_count++;
                model_heap[model_count] = k;
                pos = model_count;
                while (pos > 1 && model_heap[pos / 2] < model_heap[pos])
                begin
                    t = model_heap[pos / 2];
                    model_heap[pos / 2] = model_heap[pos];
                    model_heap[pos] = t;
                    pos = pos / 2;
                end
            end
        end
        else
        begin
            if (model_count == 0)
            begin
                r.st = ST_EMPTY;
            end
            else
            begin
                r.removed = model_heap[1];
                model_heap[1] = model_heap[model_count];
                model_count--;
                pos = 1;
                settled = 1'b0;
                while (!settled)
                begin
                    lc = 2 * pos;
                    rc = lc + 1;
                    big = pos;
                    if (lc <= model_count && model_heap[big] < model_heap[lc])
                        big = lc;
                    if (rc <= model_count && model_heap[big] < model_heap[rc])
                        big = rc;
                    if (big == pos)
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        t = model_heap[pos];
                        model_heap[pos] = model_heap[big];
                        model_heap[big] = t;
                        pos = big;
                    end
                end
            end
        end
        r.top = (model_count > 0) ? model_heap[1] : '0;
        r.count = model_count[6:0];
        return r;
    endfunction

    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] k;
        case ($urandom_range(0, 9))
            0: k = 32'sh7FFF_FFFF;
            1: k = 32'sh8000_0000;
            2, 3, 4:
            begin
                k = $urandom_range(0, 8);
                k = k - 32'sd4;
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] want_v,
                                   input logic signed [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("Mismatch in %s: expected %0d, got %0d", what, want_v, got_v);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Call at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_op(input logic op, input logic signed [31:0] k);
        heap_result_t r;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        func <= op;
        key_in <= k;
        do
            @(posedge clk);
        while (!in_ready);
        r = apply_heap_op(op, k);
        pending_results.push_back(r);
        if (r.st == ST_FULL)
            full_refusals++;
        else if (r.st == ST_EMPTY)
            empty_refusals++;
        else if (op == OP_INSERT)
            insert_count++;
        else
            remove_count++;
    endtask

    task automatic wait_drain();
        if (pending_results.size() != 0)
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_remove_empty();
        send_op(OP_REMOVE, 32'sh0);
        send_op(OP_REMOVE, 32'shFFFF_FFFF);
    endtask

    task automatic test_key_extremes();
        send_op(OP_INSERT, 32'sh7FFF_FFFF);
        send_op(OP_INSERT, 32'sh8000_0000);
        send_op(OP_INSERT, 32'sh0);
        send_op(OP_INSERT, -32'sd1);
        send_op(OP_INSERT, 32'sd1);
        send_op(OP_INSERT, 32'shAAAA_AAAA);
        send_op(OP_INSERT, 32'sh5555_5555);
        repeat (4)
            send_op(OP_REMOVE, 32'sh5555_5555);
    endtask

    task automatic test_equal_keys();
        repeat (4)
            send_op(OP_INSERT, 32'sd5);
        send_op(OP_INSERT, 32'sh8000_0000);
        repeat (3)
            send_op(OP_REMOVE, 32'sh0);
    endtask

    task automatic test_full_heap();
        while (model_count < CAPACITY)
            send_op(OP_INSERT, pick_key());
        send_op(OP_INSERT, 32'sh7FFF_FFFF);
        send_op(OP_INSERT, pick_key());
        while (model_count > 0)
            send_op(OP_REMOVE, $urandom);
        send_op(OP_REMOVE, $urandom);
    endtask

    task automatic test_random_traffic(input int n_items);
        int insert_bias;
        insert_bias = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 30 == 0)
                insert_bias = 25 * $urandom_range(1, 3);
            if (i == n_items / 2)
                wait_drain();
            if ($urandom_range(0, 99) < insert_bias)
                send_op(OP_INSERT, pick_key());
            else
                send_op(OP_REMOVE, $urandom);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        heap_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            checked_count++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transaction, top_key", 32'sh0, top_key);
            end
            else
            begin
                want = pending_results.pop_front();
                if (removed_key !== want.removed)
                    report_mismatch("removed_key", want.removed, removed_key);
                if (top_key !== want.top)
                    report_mismatch("top_key", want.top, top_key);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", 32'(want.count), 32'(entry_count));
                if (status !== want.st)
                    report_mismatch("status", 32'(want.st), 32'(status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_remove_empty();
        test_key_extremes();
        test_equal_keys();
        wait_drain();

        set_idling(38, 38);
        test_full_heap();
        wait_drain();

        set_idling(71, 0);
        test_random_traffic(310);
        set_idling(0, 71);
        test_random_traffic(310);
        set_idling(38, 38);
        test_random_traffic(310);
        set_idling(0, 0);
        test_random_traffic(310);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch("missing transactions, count", 0, pending_results.size());

        $display("Checked %0d results: %0d inserts, %0d removes, %0d full and %0d empty refusals,",
                 checked_count, insert_count, remove_count, full_refusals, empty_refusals);
        $display("covering key extremes, equal keys, a full fill and drain, and four idling mixes");
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
